[sv/zcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package zcr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int DEAD_ZONE_BITS = 15;
    localparam int FRAC_BITS      = 16;
    localparam int RATE_BITS      = FRAC_BITS + 1;
    localparam int OUT_COUNT_BITS = 16;
    localparam int ITER_BITS      = $clog2(RATE_BITS);

    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

    typedef enum logic [1:0] {
        BACK_IDLE = 2'd0,
        BACK_DIV  = 2'd1,
        BACK_DONE = 2'd2
    } back_state_t;

endpackage

`default_nettype wire

[sv/zcr_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module zcr_front #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [zcr_pkg::DEAD_ZONE_BITS-1:0]    cfg_data,
    input  wire logic                                  accept,
    input  wire logic signed [zcr_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic                                  last,
    output logic                                       frame_push,
    output logic [COUNT_BITS-1:0]                      frame_crossings,
    output logic [COUNT_BITS-1:0]                      frame_steps,
    output logic                                       frame_too_short
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [zcr_pkg::DEAD_ZONE_BITS-1:0] dead_zone_reg;
    zcr_pkg::sign_t                     kept_sign_reg, kept_sign_next;
    logic [COUNT_BITS-1:0]              crossings_reg, crossings_next;
    logic [COUNT_BITS-1:0]              steps_reg, steps_next;
    logic                               seen_reg, seen_next;

    logic signed [zcr_pkg::SAMPLE_BITS:0] sample_ext;
    logic signed [zcr_pkg::SAMPLE_BITS:0] thresh_pos;
    logic signed [zcr_pkg::SAMPLE_BITS:0] thresh_neg;
    zcr_pkg::sign_t                       cur_sign;
    logic                                 comparable;
    logic [COUNT_BITS-1:0]                crossings_upd;
    logic [COUNT_BITS-1:0]                steps_upd;

    always_comb
    begin
        sample_ext = {sample[zcr_pkg::SAMPLE_BITS-1], sample};
        thresh_pos = signed'({2'b00, dead_zone_reg});
        thresh_neg = -thresh_pos;
        if (sample_ext > thresh_pos)
        begin
            cur_sign = zcr_pkg::SIGN_POS;
        end
        else if (sample_ext < thresh_neg)
        begin
            cur_sign = zcr_pkg::SIGN_NEG;
        end
        else
        begin
            cur_sign = zcr_pkg::SIGN_NONE;
        end
    end

    always_comb
    begin
        comparable    = (kept_sign_reg != zcr_pkg::SIGN_NONE) &&
                        (cur_sign != zcr_pkg::SIGN_NONE);
        steps_upd     = steps_reg;
        crossings_upd = crossings_reg;
        if (comparable && steps_reg != COUNT_MAX)
        begin
            steps_upd = steps_reg + 1'b1;
        end
        if (comparable && kept_sign_reg != cur_sign && crossings_reg != COUNT_MAX)
        begin
            crossings_upd = crossings_reg + 1'b1;
        end

        kept_sign_next  = kept_sign_reg;
        crossings_next  = crossings_reg;
        steps_next      = steps_reg;
        seen_next       = seen_reg;
        frame_push      = 1'b0;
        frame_crossings = seen_reg ? crossings_upd : '0;
        frame_steps     = seen_reg ? steps_upd : '0;
        frame_too_short = !seen_reg;

        if (accept)
        begin
            if (last)
            begin
                frame_push     = 1'b1;
                kept_sign_next = zcr_pkg::SIGN_NONE;
                crossings_next = '0;
                steps_next     = '0;
                seen_next      = 1'b0;
            end
            else
            begin
                if (cur_sign != zcr_pkg::SIGN_NONE)
                begin
                    kept_sign_next = cur_sign;
                end
                crossings_next = crossings_upd;
                steps_next     = steps_upd;
                seen_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= '0;
            kept_sign_reg <= zcr_pkg::SIGN_NONE;
            crossings_reg <= '0;
            steps_reg     <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dead_zone_reg <= cfg_data;
            end
            kept_sign_reg <= kept_sign_next;
            crossings_reg <= crossings_next;
            steps_reg     <= steps_next;
            seen_reg      <= seen_next;
        end
    end

endmodule

`default_nettype wire

[sv/zcr_frame_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module zcr_frame_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_wr;
    logic                do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[sv/zcr_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module zcr_back #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  frame_empty,
    input  wire logic [COUNT_BITS-1:0]                 frame_crossings,
    input  wire logic [COUNT_BITS-1:0]                 frame_steps,
    input  wire logic                                  frame_too_short,
    output logic                                       frame_pop,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic [zcr_pkg::RATE_BITS-1:0]              rate,
    output logic [zcr_pkg::OUT_COUNT_BITS-1:0]         crossing_count,
    output logic [zcr_pkg::OUT_COUNT_BITS-1:0]         step_count,
    output logic                                       too_short
);

    localparam logic [zcr_pkg::ITER_BITS-1:0] ITER_LAST =
        zcr_pkg::ITER_BITS'(zcr_pkg::RATE_BITS - 1);

    zcr_pkg::back_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0]             crossings_reg, crossings_next;
    logic [COUNT_BITS-1:0]             steps_reg, steps_next;
    logic                              short_reg, short_next;
    logic [COUNT_BITS:0]               rem_reg, rem_next;
    logic [zcr_pkg::RATE_BITS-1:0]     quot_reg, quot_next;
    logic [zcr_pkg::ITER_BITS-1:0]     iter_reg, iter_next;

    logic [COUNT_BITS:0]               trial;
    logic                              fits;
    logic [COUNT_BITS+zcr_pkg::OUT_COUNT_BITS-1:0] crossings_wide;
    logic [COUNT_BITS+zcr_pkg::OUT_COUNT_BITS-1:0] steps_wide;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            zcr_pkg::BACK_IDLE:
            begin
                if (!frame_empty)
                begin
                    state_next = (frame_steps == '0) ? zcr_pkg::BACK_DONE
                                                     : zcr_pkg::BACK_DIV;
                end
            end
            zcr_pkg::BACK_DIV:
            begin
                if (iter_reg == ITER_LAST)
                begin
                    state_next = zcr_pkg::BACK_DONE;
                end
            end
            zcr_pkg::BACK_DONE:
            begin
                if (pop)
                begin
                    state_next = zcr_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = zcr_pkg::BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        frame_pop = (state_reg == zcr_pkg::BACK_IDLE) && !frame_empty;
        empty     = (state_reg != zcr_pkg::BACK_DONE);
    end

    // restoring division: first step compares the bare count, later ones shift
    always_comb
    begin
        trial = (iter_reg == '0) ? rem_reg : {rem_reg[COUNT_BITS-1:0], 1'b0};
        fits  = (trial >= {1'b0, steps_reg});

        crossings_next = crossings_reg;
        steps_next     = steps_reg;
        short_next     = short_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        iter_next      = iter_reg;

        if (frame_pop)
        begin
            crossings_next = frame_crossings;
            steps_next     = frame_steps;
            short_next     = frame_too_short;
            rem_next       = {1'b0, frame_crossings};
            quot_next      = '0;
            iter_next      = '0;
        end
        else if (state_reg == zcr_pkg::BACK_DIV)
        begin
            rem_next  = fits ? trial - {1'b0, steps_reg} : trial;
            quot_next = {quot_reg[zcr_pkg::RATE_BITS-2:0], fits};
            iter_next = iter_reg + 1'b1;
        end
    end

    always_comb
    begin
        crossings_wide = {{zcr_pkg::OUT_COUNT_BITS{1'b0}}, crossings_reg};
        steps_wide     = {{zcr_pkg::OUT_COUNT_BITS{1'b0}}, steps_reg};
        rate           = quot_reg;
        crossing_count = crossings_wide[zcr_pkg::OUT_COUNT_BITS-1:0];
        step_count     = steps_wide[zcr_pkg::OUT_COUNT_BITS-1:0];
        too_short      = short_reg;
    end

    always_ff @(posedge clk)
    begin
        crossings_reg <= crossings_next;
        steps_reg     <= steps_next;
        short_reg     <= short_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zcr_pkg::BACK_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

`default_nettype wire

[sv/zero_crossing_rate_threshold_unit.sv]
// Throughput: one sample beat per cycle unless full; full rises only while the frame queue is full.
// A frame result shows once the back end has loaded it from the queue and the
// one-bit-per-cycle divider has run; a frame with no steps skips the divider.
// The divider takes a new frame only after the last result is popped, so frames that come faster queue up.
// Reset (rst_n low, asynchronous) clears frame state, queue pointers and the
// divider sequencer, and sets the dead zone to 0.
`timescale 1ns / 1ps
`default_nettype none

module zero_crossing_rate_threshold_unit #(
    parameter int COUNT_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [zcr_pkg::DEAD_ZONE_BITS-1:0]     cfg_data,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic signed [zcr_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic                                   last,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic [zcr_pkg::RATE_BITS-1:0]               rate,
    output logic [zcr_pkg::OUT_COUNT_BITS-1:0]          crossing_count,
    output logic [zcr_pkg::OUT_COUNT_BITS-1:0]          step_count,
    output logic                                        too_short
);

    localparam int ENTRY_BITS = 2 * COUNT_BITS + 1;

    logic                   accept;
    logic                   frame_push;
    logic [COUNT_BITS-1:0]  push_crossings;
    logic [COUNT_BITS-1:0]  push_steps;
    logic                   push_too_short;
    logic [ENTRY_BITS-1:0]  head;
    logic                   frame_pop;
    logic                   frame_empty;

    assign accept = push && !full;

    zcr_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .accept          (accept),
        .sample          (sample),
        .last            (last),
        .frame_push      (frame_push),
        .frame_crossings (push_crossings),
        .frame_steps     (push_steps),
        .frame_too_short (push_too_short)
    );

    zcr_frame_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (frame_push),
        .wr_data ({push_too_short, push_steps, push_crossings}),
        .rd_en   (frame_pop),
        .rd_data (head),
        .full    (full),
        .empty   (frame_empty)
    );

    zcr_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_empty     (frame_empty),
        .frame_crossings (head[COUNT_BITS-1:0]),
        .frame_steps     (head[2*COUNT_BITS-1:COUNT_BITS]),
        .frame_too_short (head[2*COUNT_BITS]),
        .frame_pop       (frame_pop),
        .empty           (empty),
        .pop             (pop),
        .rate            (rate),
        .crossing_count  (crossing_count),
        .step_count      (step_count),
        .too_short       (too_short)
    );

endmodule

`default_nettype wire
